// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Antecedent implies the consequent at the same edge.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`endif

`endif

// ----- rtl/tspf_pkg.sv -----
// ----------------------------------------------------------------------------
// Transport stream PID filter package
// Types, constants and codes shared by the filter modules.
// ----------------------------------------------------------------------------
package tspf_pkg;

  localparam int CHANNELS     = 4;
  localparam int SLOT_W       = 2;
  localparam int PACKET_BYTES = 188;
  localparam int POS_W        = $clog2(PACKET_BYTES);
  localparam int Q_DEPTH      = 3;
  localparam int QPTR_W       = 2;

  typedef logic [2:0]       evt_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [12:0]      pid_t;
  typedef logic [7:0]       byte_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [3:0]       cc_t;
  typedef logic [2:0]       cfg_idx_t;
  typedef logic [12:0]      cfg_data_t;
  typedef logic [QPTR_W-1:0] qptr_t;

  // Event codes.
  localparam evt_t EVT_PAYLOAD   = 3'd0;
  localparam evt_t EVT_HEADER    = 3'd1;
  localparam evt_t EVT_UNKNOWN   = 3'd2;
  localparam evt_t EVT_SYNC_LOST = 3'd3;
  localparam evt_t EVT_SCRAMBLED = 3'd4;

  // Register indexes.
  localparam cfg_idx_t REG_CHANNELS_IN_USE = 3'd0;
  localparam cfg_idx_t REG_CHAN0_PID       = 3'd1;

  // Stream constants.
  localparam byte_t SYNC_VALUE = 8'h47;
  localparam logic [1:0] AFC_PAYLOAD = 2'h1;
  localparam logic [1:0] AFC_BOTH    = 2'h3;

  localparam pos_t POS_SYNC      = POS_W'(0);
  localparam pos_t POS_HDR1      = POS_W'(1);
  localparam pos_t POS_HDR2      = POS_W'(2);
  localparam pos_t POS_HDR3      = POS_W'(3);
  localparam pos_t POS_ADAPT_LEN = POS_W'(4);
  localparam pos_t LAST_POS      = POS_W'(PACKET_BYTES - 1);

  localparam pos_t OFF_NONE  = POS_W'(PACKET_BYTES);
  localparam pos_t OFF_PLAIN = POS_W'(4);
  localparam pos_t OFF_ADAPT = POS_W'(5);

  typedef struct packed {
    logic [2:0]                ch_in_use;
    pid_t [CHANNELS-1:0]       chan_pid;
  } cfg_t;

  typedef struct packed {
    evt_t  event_res;
    slot_t channel;
    pid_t  packet_pid;
    byte_t data_byte;
    logic  unit_start;
    logic  cc_error;
    logic  transport_err;
    logic  last_of_packet;
  } result_t;

  typedef struct packed {
    logic busy;
    logic halted;
    logic push;
  } core_status_t;

endpackage

// ----- rtl/tspf_in_if.sv -----
// ----------------------------------------------------------------------------
// Stream byte channel
// Valid/ready channel carrying one transport stream byte per transaction.
// ----------------------------------------------------------------------------
interface tspf_in_if;
  logic             valid;
  logic             ready;
  tspf_pkg::byte_t  ts_byte;

  modport source (output valid, output ts_byte, input ready);
  modport sink (input valid, input ts_byte, output ready);
endinterface

// ----- rtl/tspf_out_if.sv -----
// ----------------------------------------------------------------------------
// Filter result channel
// Valid/ready channel carrying one filter event per transaction.
// ----------------------------------------------------------------------------
interface tspf_out_if;
  logic             valid;
  logic             ready;
  tspf_pkg::evt_t   event_res;
  tspf_pkg::slot_t  channel;
  tspf_pkg::pid_t   packet_pid;
  tspf_pkg::byte_t  data_byte;
  logic             unit_start;
  logic             cc_error;
  logic             transport_err;
  logic             last_of_packet;

  modport source (output valid, output event_res, output channel, output packet_pid,
                  output data_byte, output unit_start, output cc_error,
                  output transport_err, output last_of_packet, input ready);
  modport sink (input valid, input event_res, input channel, input packet_pid,
                input data_byte, input unit_start, input cc_error,
                input transport_err, input last_of_packet, output ready);
endinterface

// ----- rtl/tspf_cfg.sv -----
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the active slot count and the per-slot PIDs.
// ----------------------------------------------------------------------------
module tspf_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  tspf_pkg::cfg_idx_t  cfg_index,
  input  tspf_pkg::cfg_data_t cfg_data,
  output tspf_pkg::cfg_t      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      if (cfg_index == tspf_pkg::REG_CHANNELS_IN_USE) begin
        cfg.ch_in_use <= cfg_data[2:0];
      end
      for (int k = 0; k < tspf_pkg::CHANNELS; k++) begin
        if (32'(cfg_index) == 32'(tspf_pkg::REG_CHAN0_PID) + 32'(k)) begin
          cfg.chan_pid[k] <= cfg_data;
        end
      end
    end
  end

endmodule

// ----- rtl/tspf_core.sv -----
// ----------------------------------------------------------------------------
// Packet parser core
// Input byte register, packet state and single-pass event generation.
// ----------------------------------------------------------------------------
module tspf_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_accept,
  input  tspf_pkg::byte_t        in_byte,
  input  tspf_pkg::cfg_t         cfg,
  output tspf_pkg::core_status_t status,
  output tspf_pkg::result_t      res
);

  logic                    busy;
  tspf_pkg::byte_t         byte_q;
  tspf_pkg::pos_t          pos, pos_next;
  tspf_pkg::pos_t          offset, offset_next;
  tspf_pkg::slot_t         slot, slot_next;
  logic                    halted, halted_next;
  logic                    tei, tei_next;
  logic                    pusi, pusi_next;
  tspf_pkg::pid_t          pid, pid_next;
  tspf_pkg::cc_t           cc_exp [tspf_pkg::CHANNELS];
  tspf_pkg::cc_t           cc_exp_next [tspf_pkg::CHANNELS];
  logic                    push;

  logic                    found;
  tspf_pkg::slot_t         hit_slot;
  tspf_pkg::pid_t          hdr_pid;
  logic [tspf_pkg::POS_W:0] adapt_end;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= in_accept;
    end
    if (in_accept) begin
      byte_q <= in_byte;
    end
  end

  assign hdr_pid = pid;

  // Lowest active slot whose PID matches wins.
  always_comb begin
    found    = 1'b0;
    hit_slot = '0;
    for (int k = tspf_pkg::CHANNELS - 1; k >= 0; k--) begin
      if (int'(cfg.ch_in_use) > k && cfg.chan_pid[k] == hdr_pid) begin
        found    = 1'b1;
        hit_slot = tspf_pkg::SLOT_W'(k);
      end
    end
  end

  assign adapt_end = {1'b0, byte_q} + (tspf_pkg::POS_W + 1)'(tspf_pkg::OFF_ADAPT);

  always_comb begin
    pos_next    = pos;
    offset_next = offset;
    slot_next   = slot;
    halted_next = halted;
    tei_next    = tei;
    pusi_next   = pusi;
    pid_next    = pid;
    cc_exp_next = cc_exp;
    push        = 1'b0;
    res         = '0;
    if (busy && !halted) begin
      pos_next = (pos == tspf_pkg::LAST_POS) ? '0 : pos + tspf_pkg::POS_W'(1);
      if (pos == tspf_pkg::POS_SYNC) begin
        if (byte_q != tspf_pkg::SYNC_VALUE) begin
          push          = 1'b1;
          res.event_res = tspf_pkg::EVT_SYNC_LOST;
          halted_next   = 1'b1;
        end else begin
          tei_next    = 1'b0;
          pusi_next   = 1'b0;
          pid_next    = '0;
          offset_next = tspf_pkg::OFF_NONE;
        end
      end else if (pos == tspf_pkg::POS_HDR1) begin
        tei_next  = byte_q[7];
        pusi_next = byte_q[6];
        pid_next  = {byte_q[4:0], pid[7:0]};
      end else if (pos == tspf_pkg::POS_HDR2) begin
        pid_next = {pid[12:8], byte_q};
      end else if (pos == tspf_pkg::POS_HDR3) begin
        offset_next        = tspf_pkg::OFF_NONE;
        res.packet_pid     = pid;
        res.unit_start     = pusi;
        res.transport_err  = tei;
        if (byte_q[7:6] != 2'b00) begin
          push          = 1'b1;
          res.event_res = tspf_pkg::EVT_SCRAMBLED;
          halted_next   = 1'b1;
        end else if (byte_q[5:4] == tspf_pkg::AFC_PAYLOAD ||
                     byte_q[5:4] == tspf_pkg::AFC_BOTH) begin
          push = 1'b1;
          if (!found) begin
            res.event_res = tspf_pkg::EVT_UNKNOWN;
          end else begin
            res.event_res          = tspf_pkg::EVT_HEADER;
            res.channel            = hit_slot;
            res.cc_error           = (cc_exp[hit_slot] != byte_q[3:0]);
            cc_exp_next[hit_slot]  = byte_q[3:0] + 4'd1;
            slot_next              = hit_slot;
            offset_next = (byte_q[5:4] == tspf_pkg::AFC_BOTH) ? tspf_pkg::OFF_ADAPT
                                                               : tspf_pkg::OFF_PLAIN;
          end
        end else begin
          res = '0;
        end
      end else if (pos == tspf_pkg::POS_ADAPT_LEN && offset == tspf_pkg::OFF_ADAPT) begin
        // An adaptation field running past the packet end leaves no payload.
        offset_next = (adapt_end > (tspf_pkg::POS_W + 1)'(tspf_pkg::PACKET_BYTES))
                      ? tspf_pkg::OFF_NONE : adapt_end[tspf_pkg::POS_W-1:0];
      end else if (pos >= offset) begin
        push               = 1'b1;
        res.event_res      = tspf_pkg::EVT_PAYLOAD;
        res.channel        = slot;
        res.packet_pid     = pid;
        res.data_byte      = byte_q;
        res.unit_start     = pusi;
        res.transport_err  = tei;
        res.last_of_packet = (pos == tspf_pkg::LAST_POS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      offset <= tspf_pkg::OFF_PLAIN;
      slot   <= '0;
      halted <= 1'b0;
      tei    <= 1'b0;
      pusi   <= 1'b0;
      pid    <= '0;
      for (int k = 0; k < tspf_pkg::CHANNELS; k++) begin
        cc_exp[k] <= '0;
      end
    end else begin
      pos    <= pos_next;
      offset <= offset_next;
      slot   <= slot_next;
      halted <= halted_next;
      tei    <= tei_next;
      pusi   <= pusi_next;
      pid    <= pid_next;
      cc_exp <= cc_exp_next;
    end
  end

  assign status.busy   = busy;
  assign status.halted = halted;
  assign status.push   = push;

endmodule

// ----- rtl/tspf_outq.sv -----
// ----------------------------------------------------------------------------
// Result queue
// Small FIFO of filter events that decouples the parser from the receiver.
// ----------------------------------------------------------------------------
module tspf_outq (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tspf_pkg::result_t  push_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tspf_pkg::result_t  out_data,
  output tspf_pkg::qptr_t    level
);

  tspf_pkg::result_t entry [tspf_pkg::Q_DEPTH];
  tspf_pkg::qptr_t   wr_ptr;
  tspf_pkg::qptr_t   rd_ptr;
  logic              pop;

  assign out_valid = (level != '0);
  assign pop       = out_valid && out_ready;
  assign out_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == tspf_pkg::QPTR_W'(tspf_pkg::Q_DEPTH - 1))
                  ? '0 : wr_ptr + tspf_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == tspf_pkg::QPTR_W'(tspf_pkg::Q_DEPTH - 1))
                  ? '0 : rd_ptr + tspf_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        level <= level + tspf_pkg::QPTR_W'(1);
      end else if (pop && !push) begin
        level <= level - tspf_pkg::QPTR_W'(1);
      end
    end
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- rtl/ts_packet_pid_filter_top.sv -----
// ----------------------------------------------------------------------------
// Transport stream PID filter, top level
// Sync check, header parse, PID match, continuity check and payload pass.
// ----------------------------------------------------------------------------
// Usage:
//   ts_in carries one transport stream byte per transaction, packets of 188
//   bytes back to back starting with a sync byte. res_out carries at most one
//   event per byte: payload byte, header accepted, unknown PID, sync lost or
//   scrambled. The cfg port writes the slot count and the slot PIDs; write it
//   only while no byte is in flight.
//   A taken byte is registered into the parse stage, and its event is then
//   registered into the result queue before the receiver can take it.
//   Throughput: one byte per clock while ts_in.ready is high.
//   A three-entry result queue sits after the parse stage; ts_in.ready drops
//   only when the queue plus the byte in the parse stage could fill it, so a
//   stalled receiver backs up the stream and nothing is lost.
//   After a sync loss or a scrambled packet the block swallows all bytes with
//   no events until rst. Reset clears packet state, counters and registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ts_packet_pid_filter_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  tspf_pkg::cfg_idx_t  cfg_index,
  input  tspf_pkg::cfg_data_t cfg_data,
  tspf_in_if.sink             ts_in,
  tspf_out_if.source          res_out
);

  tspf_pkg::cfg_t         cfg;
  tspf_pkg::core_status_t status;
  tspf_pkg::result_t      core_res;
  tspf_pkg::result_t      q_data;
  tspf_pkg::qptr_t        level;
  logic                   in_accept;

  assign ts_in.ready = ({1'b0, level} + {2'b00, status.busy})
                       < (tspf_pkg::QPTR_W + 1)'(tspf_pkg::Q_DEPTH);
  assign in_accept   = ts_in.valid && ts_in.ready;

  tspf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tspf_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .in_byte   (ts_in.ts_byte),
    .cfg       (cfg),
    .status    (status),
    .res       (core_res)
  );

  tspf_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (status.push),
    .push_data (core_res),
    .out_valid (res_out.valid),
    .out_ready (res_out.ready),
    .out_data  (q_data),
    .level     (level)
  );

  assign res_out.event_res      = q_data.event_res;
  assign res_out.channel        = q_data.channel;
  assign res_out.packet_pid     = q_data.packet_pid;
  assign res_out.data_byte      = q_data.data_byte;
  assign res_out.unit_start     = q_data.unit_start;
  assign res_out.cc_error       = q_data.cc_error;
  assign res_out.transport_err  = q_data.transport_err;
  assign res_out.last_of_packet = q_data.last_of_packet;

  // The queue must never be asked to hold more than its depth.
  `ASSERT_ALWAYS(a_level_bound, clk, rst, level <= tspf_pkg::QPTR_W'(tspf_pkg::Q_DEPTH), "result queue overfilled")
  `ASSERT_IMPLIES(a_push_room, clk, rst, status.push && !(res_out.valid && res_out.ready), level < tspf_pkg::QPTR_W'(tspf_pkg::Q_DEPTH), "push into a full result queue")
  // Once halted, the parser produces no more events.
  `ASSERT_IMPLIES(a_halt_quiet, clk, rst, status.halted, !status.push, "event produced while halted")

endmodule
